FILE: src/kprm_pkg.sv
// ---------------------------------------------------------------------------
// Key press rate meter package
// Item types of the request and response channels and the fixed field widths
// and codes that the meter uses.
// ---------------------------------------------------------------------------
package kprm_pkg;

   localparam int KEY_W   = 8;
   localparam int COUNT_W = 9;
   localparam int TOTAL_W = 32;
   localparam int RATE_W  = 21;
   localparam int MULT_W  = 8;

   // Beat rate scale: 15 beats per press count, 8 fraction bits.
   localparam int RATE_SCALE = 3840;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   localparam logic [MULT_W-1:0] MULT_RESET = 8'd1;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] pressed_keys;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] presses_in_window;
      logic [COUNT_W-1:0] peak_presses;
      logic [TOTAL_W-1:0] press_total;
      logic [RATE_W-1:0]  beat_rate;
   } rsp_type;

endpackage

FILE: src/key_press_rate_meter_core.sv
// ---------------------------------------------------------------------------
// Key press rate meter core
// Counts key presses over a sliding window of frames, tracks the peak window
// count and a weighted running total, and derives a beat rate from a short
// history of the per-key counts.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   req       in          req_valid / req_ready   kprm_pkg::req_type
//   rsp       out         rsp_valid / rsp_ready   kprm_pkg::rsp_type
//   csr       in          csr_valid / csr_ready   press multiplier, 8 bits
//
// After acceptance a frame item passes through these steps to the response
// register: a load of the window marks, one key per cycle through the
// shared count update, then the rate scale, the reciprocal multiply and the
// final step. A clear item goes from idle straight to the final step. A new
// item is taken only once the last one has left the final step.
// Reset clears all statistics at once through per-entry valid bits of the
// two memories, so no clearing pass follows it.
// A new item is accepted while a response still waits; the final step holds
// until the response register is free.
//
module key_press_rate_meter_core #(
   parameter int BUTTONS = 8,
   parameter int WINDOW  = 60,
   parameter int HISTORY = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kprm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output kprm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kprm_pkg::MULT_W-1:0]       csr_data
);

   localparam int KW   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
   localparam int HSW  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
   localparam int WSW  = $clog2(WINDOW);
   localparam int HD   = 2 ** (KW + HSW);
   localparam int CW   = $clog2(WINDOW + 1);
   localparam int WCW  = $clog2(BUTTONS * WINDOW + 1);
   localparam int SW   = $clog2(BUTTONS * HISTORY * WINDOW + 1);
   localparam int XW   = SW + $clog2(kprm_pkg::RATE_SCALE + 1);
   localparam int PW   = 2 * XW + 1;
   localparam int LW   = (BUTTONS > kprm_pkg::KEY_W) ? BUTTONS : kprm_pkg::KEY_W;
   localparam int OCW  = (WCW > kprm_pkg::COUNT_W) ? WCW : kprm_pkg::COUNT_W;
   localparam int QW   = (XW > kprm_pkg::RATE_W) ? XW : kprm_pkg::RATE_W;
   localparam logic [XW:0] RECIP = (XW + 1)'((64'd1 << XW) / 64'(HISTORY));
   localparam logic [kprm_pkg::COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [kprm_pkg::RATE_W-1:0]  RATE_MAX  = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_KEY,
      ST_SCALE,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type                    state_ff;
   logic                         rsp_valid_ff;
   kprm_pkg::rsp_type            rsp_data_ff;
   logic [kprm_pkg::MULT_W-1:0]  mult_ff;
   logic [KW-1:0]                key_ff;
   logic [WSW-1:0]               ws_ff;
   logic [HSW-1:0]               hs_ff;
   logic [BUTTONS-1:0]           last_ff;
   logic [BUTTONS-1:0]           lvl_ff;
   logic [BUTTONS-1:0]           row_ff;
   logic [WCW-1:0]               wc_ff;
   logic [WCW-1:0]               peak_ff;
   logic [kprm_pkg::TOTAL_W-1:0] total_ff;
   logic [SW-1:0]                s_ff;
   logic [CW-1:0]                key_cnt_ff [BUTTONS];
   logic [WINDOW-1:0]            mark_vld_ff;
   logic [HD-1:0]                hist_vld_ff;
   logic [XW-1:0]                x_ff;
   logic [PW-1:0]                prod_ff;

   logic [BUTTONS-1:0]           mark_mem [WINDOW];
   logic [BUTTONS-1:0]           mark_q_ff;
   logic [CW-1:0]                hist_mem [HD];
   logic [CW-1:0]                hist_q_ff;

   logic [LW-1:0]                keys_wide;
   logic [BUTTONS-1:0]           lvl_in;
   logic                         frame_start;
   logic                         key_last;
   logic                         expire;
   logic                         rise;
   logic [CW-1:0]                cnt_cur;
   logic [CW-1:0]                cnt_dec;
   logic [CW-1:0]                key_cnt_in;
   logic [WCW-1:0]               wc_dec;
   logic [WCW-1:0]               wc_in;
   logic [WCW-1:0]               peak_in;
   logic [kprm_pkg::TOTAL_W-1:0] total_in;
   logic [SW-1:0]                s_in;
   logic                         hist_re;
   logic [KW+HSW-1:0]            hist_raddr;
   logic [KW+HSW-1:0]            hist_waddr;
   logic [XW-1:0]                q_lo;
   logic [XW-1:0]                qh;
   logic [XW-1:0]                rem;
   logic                         rem_fix;
   logic [XW-1:0]                rem_left;
   logic [XW-1:0]                q_fix;
   logic [QW-1:0]                q_wide;
   logic [OCW-1:0]               wc_wide;
   logic [OCW-1:0]               peak_wide;
   kprm_pkg::rsp_type            rsp_data_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      keys_wide   = LW'(req_data.pressed_keys);
      lvl_in      = keys_wide[BUTTONS-1:0];
      frame_start = (state_ff == ST_IDLE) && req_valid
                    && (req_data.kind == kprm_pkg::KIND_FRAME);
      key_last    = (key_ff == KW'(BUTTONS - 1));

      cnt_cur    = key_cnt_ff[key_ff];
      expire     = row_ff[key_ff];
      rise       = lvl_ff[key_ff] & ~last_ff[key_ff];
      cnt_dec    = (expire && (cnt_cur != '0)) ? cnt_cur - CW'(1) : cnt_cur;
      key_cnt_in = rise ? cnt_dec + CW'(1) : cnt_dec;
      wc_dec     = (expire && (wc_ff != '0)) ? wc_ff - WCW'(1) : wc_ff;
      wc_in      = rise ? wc_dec + WCW'(1) : wc_dec;
      peak_in    = (wc_in > peak_ff) ? wc_in : peak_ff;
      total_in   = rise ? total_ff + kprm_pkg::TOTAL_W'(mult_ff) : total_ff;
      s_in       = s_ff + SW'(key_cnt_in) - SW'(hist_q_ff);

      hist_re    = frame_start || ((state_ff == ST_KEY) && !key_last);
      hist_raddr = frame_start ? {KW'(0), hs_ff} : {KW'(key_ff + 1'b1), hs_ff};
      hist_waddr = {key_ff, hs_ff};

      q_lo     = prod_ff[XW-1+XW:XW];
      qh       = XW'(q_lo * XW'(HISTORY));
      rem      = x_ff - qh;
      rem_fix  = (rem >= XW'(HISTORY));
      rem_left = rem_fix ? rem - XW'(HISTORY) : rem;
      q_fix    = rem_fix ? q_lo + XW'(1) : q_lo;
      q_wide   = QW'(q_fix);

      wc_wide   = OCW'(wc_ff);
      peak_wide = OCW'(peak_ff);
      rsp_data_in.presses_in_window = (wc_wide > OCW'(COUNT_MAX))
                                      ? COUNT_MAX : wc_wide[kprm_pkg::COUNT_W-1:0];
      rsp_data_in.peak_presses      = (peak_wide > OCW'(COUNT_MAX))
                                      ? COUNT_MAX : peak_wide[kprm_pkg::COUNT_W-1:0];
      rsp_data_in.press_total       = total_ff;
      rsp_data_in.beat_rate         = (q_wide > QW'(RATE_MAX))
                                      ? RATE_MAX : q_wide[kprm_pkg::RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         mark_mem[ws_ff] <= row_ff;
      end
      if (frame_start) begin
         mark_q_ff <= mark_vld_ff[ws_ff] ? mark_mem[ws_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_KEY) begin
         hist_mem[hist_waddr] <= key_cnt_in;
      end
      if (hist_re) begin
         hist_q_ff <= hist_vld_ff[hist_raddr] ? hist_mem[hist_raddr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mult_ff      <= kprm_pkg::MULT_RESET;
         key_ff       <= '0;
         ws_ff        <= '0;
         hs_ff        <= '0;
         last_ff      <= '0;
         wc_ff        <= '0;
         peak_ff      <= '0;
         total_ff     <= '0;
         s_ff         <= '0;
         key_cnt_ff   <= '{default: '0};
         mark_vld_ff  <= '0;
         hist_vld_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            mult_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_data.kind == kprm_pkg::KIND_CLEAR) begin
                     wc_ff       <= '0;
                     peak_ff     <= '0;
                     total_ff    <= '0;
                     s_ff        <= '0;
                     key_cnt_ff  <= '{default: '0};
                     mark_vld_ff <= '0;
                     hist_vld_ff <= '0;
                     x_ff        <= '0;
                     prod_ff     <= '0;
                     state_ff    <= ST_FINISH;
                  end else begin
                     lvl_ff   <= lvl_in;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               row_ff   <= mark_q_ff;
               key_ff   <= '0;
               state_ff <= ST_KEY;
            end
            ST_KEY: begin
               key_cnt_ff[key_ff]      <= key_cnt_in;
               wc_ff                   <= wc_in;
               peak_ff                 <= peak_in;
               total_ff                <= total_in;
               s_ff                    <= s_in;
               row_ff[key_ff]          <= rise;
               hist_vld_ff[hist_waddr] <= 1'b1;
               if (key_last) begin
                  key_ff   <= '0;
                  state_ff <= ST_SCALE;
               end else begin
                  key_ff <= KW'(key_ff + 1'b1);
               end
            end
            ST_SCALE: begin
               mark_vld_ff[ws_ff] <= 1'b1;
               x_ff     <= XW'(XW'(s_ff) * XW'(kprm_pkg::RATE_SCALE));
               last_ff  <= lvl_ff;
               ws_ff    <= (ws_ff == WSW'(WINDOW - 1)) ? '0 : WSW'(ws_ff + 1'b1);
               hs_ff    <= (hs_ff == HSW'(HISTORY - 1)) ? '0 : HSW'(hs_ff + 1'b1);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= PW'(x_ff) * PW'(RECIP);
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= rsp_data_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_peak_covers_window: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= wc_ff)
      else $error("Peak count fell below the window count.");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.kind == kprm_pkg::KIND_CLEAR))
      |=> (wc_ff == '0) && (peak_ff == '0) && (total_ff == '0) && (s_ff == '0))
      else $error("A clear item left statistics behind.");

   a_rate_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (rem_left < XW'(HISTORY)))
      else $error("Reciprocal quotient is off by more than one.");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("Response raised outside the final step.");

endmodule

FILE: sim/key_press_rate_meter_core_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key press rate meter response checker
// Watches the request, response and register channels of the meter. It keeps
// its own sliding window of key presses, per-key count history, peak and
// weighted total. For every accepted request it predicts the response and
// compares each accepted response field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module key_press_rate_meter_core_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  kprm_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  kprm_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [kprm_pkg::MULT_W-1:0] csr_data,
   output int                          pending,
   output int                          failures,
   output int                          checked
);

   localparam int KEYS    = 8;
   localparam int SPAN    = 60;
   localparam int DEPTH   = 7;
   localparam int KEY_W   = kprm_pkg::KEY_W;
   localparam int COUNT_W = kprm_pkg::COUNT_W;
   localparam int TOTAL_W = kprm_pkg::TOTAL_W;
   localparam int RATE_W  = kprm_pkg::RATE_W;
   localparam int MULT_W  = kprm_pkg::MULT_W;
   localparam longint unsigned RATE_MAX = (64'd1 << RATE_W) - 1;

   logic [KEY_W-1:0]   marks [SPAN];
   logic [5:0]         key_count [KEYS];
   logic [5:0]         count_ring [KEYS][DEPTH];
   int unsigned        span_slot;
   int unsigned        ring_slot;
   logic [KEY_W-1:0]   prev_levels;
   logic [COUNT_W-1:0] live_count;
   logic [COUNT_W-1:0] peak;
   logic [TOTAL_W-1:0] total;
   logic [MULT_W-1:0]  multiplier;
   kprm_pkg::rsp_type  expected_rsp [$];
   int                 fail_count;
   int                 rsp_count;

   function automatic void clear_stats();
      for (int s = 0; s < SPAN; s++) marks[s] = '0;
      for (int k = 0; k < KEYS; k++) begin
         key_count[k] = '0;
         for (int h = 0; h < DEPTH; h++) count_ring[k][h] = '0;
      end
      live_count = '0;
      peak = '0;
      total = '0;
   endfunction

   function automatic kprm_pkg::rsp_type meter_step(kprm_pkg::req_type item);
      kprm_pkg::rsp_type r;
      longint unsigned   ring_sum;
      longint unsigned   rate;
      r = '0;
      ring_sum = 0;
      if (item.kind == kprm_pkg::KIND_CLEAR) begin
         clear_stats();
         return r;
      end
      for (int k = 0; k < KEYS; k++) begin
         if (marks[span_slot][k]) begin
            marks[span_slot][k] = 1'b0;
            if (key_count[k] != 0) key_count[k] = key_count[k] - 1'b1;
            if (live_count != 0) live_count = live_count - 1'b1;
         end
         if (item.pressed_keys[k] && !prev_levels[k]) begin
            marks[span_slot][k] = 1'b1;
            key_count[k] = key_count[k] + 1'b1;
            live_count = live_count + 1'b1;
            if (live_count > peak) peak = live_count;
            total = total + multiplier;
         end
         count_ring[k][ring_slot] = key_count[k];
      end
      for (int k = 0; k < KEYS; k++)
         for (int h = 0; h < DEPTH; h++) ring_sum += count_ring[k][h];
      rate = (ring_sum * kprm_pkg::RATE_SCALE) / DEPTH;
      if (rate > RATE_MAX) rate = RATE_MAX;
      prev_levels = item.pressed_keys;
      span_slot = (span_slot + 1) % SPAN;
      ring_slot = (ring_slot + 1) % DEPTH;
      r.presses_in_window = live_count;
      r.peak_presses = peak;
      r.press_total = total;
      r.beat_rate = rate[RATE_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      kprm_pkg::rsp_type want;
      if (reset) begin
         clear_stats();
         multiplier = kprm_pkg::MULT_RESET;
         span_slot = 0;
         ring_slot = 0;
         prev_levels = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("presses_in_window", want.presses_in_window,
                           rsp_data.presses_in_window);
               check_field("peak_presses", want.peak_presses, rsp_data.peak_presses);
               check_field("press_total", want.press_total, rsp_data.press_total);
               check_field("beat_rate", want.beat_rate, rsp_data.beat_rate);
               rsp_count++;
            end
         end
         if (csr_valid && csr_ready) multiplier = csr_data;
         if (req_valid && req_ready) expected_rsp.push_back(meter_step(req_data));
      end
      pending <= expected_rsp.size();
      failures <= fail_count;
      checked <= rsp_count;
   end

endmodule

FILE: sim/key_press_rate_meter_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key press rate meter testbench
// Drives frame and clear items through the meter under several multiplier
// settings, with bursty requests, a stalling response side and one long
// response hold-off. A checker beside the meter predicts and compares every
// response; this top module makes the stimulus and reports the verdict.
// ---------------------------------------------------------------------------
module key_press_rate_meter_core_tb;

   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 200;
   localparam int LONG_HOLD    = 300;
   localparam int KEY_W        = kprm_pkg::KEY_W;
   localparam int MULT_W       = kprm_pkg::MULT_W;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kprm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kprm_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MULT_W-1:0] csr_data = '0;

   int      pending;
   int      failures;
   int      checked;
   int      hold_requests = 0;
   int      idle_cycles = 0;
   int      burst_left = 10;
   int      frame_items = 0;
   int      clear_items = 0;
   int      settings = 0;
   kprm_pkg::req_type item_queue [$];

   key_press_rate_meter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   key_press_rate_meter_core_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .pending   (pending),
      .failures  (failures),
      .checked   (checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The response side alternates between stall patterns of random length
   // and serves long hold-off requests from the stimulus.
   int holds_done = 0;
   int hold_left = 0;
   int pattern = 0;
   int pattern_left = 0;
   int phase_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done = hold_requests;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern = $urandom_range(0, 3);
            pattern_left = $urandom_range(5, 80);
         end
         pattern_left--;
         phase_count++;
         case (pattern)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (phase_count % 5 != 0);
         endcase
      end
   end

   task automatic add_item(logic kind, logic [KEY_W-1:0] keys);
      kprm_pkg::req_type item;
      item.kind = kind;
      item.pressed_keys = keys;
      item_queue.push_back(item);
      if (kind == kprm_pkg::KIND_CLEAR) clear_items++;
      else frame_items++;
   endtask

   task automatic play_items();
      while (item_queue.size() > 0) begin
         req_valid <= 1'b1;
         req_data <= item_queue.pop_front();
         do @(posedge clock); while (!req_ready);
         burst_left--;
         if (item_queue.size() == 0 || burst_left <= 0) begin
            req_valid <= 1'b0;
            if (burst_left <= 0) begin
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                        : $urandom_range(1, 20);
            end
         end
      end
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_multiplier(logic [MULT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic build_random_phase(int count);
      logic [KEY_W-1:0] levels;
      int               style;
      int               style_left;
      levels = '0;
      style = 0;
      style_left = 0;
      for (int n = 0; n < count; n++) begin
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(10, 80);
         end
         style_left--;
         if ($urandom_range(0, 99) < 2) begin
            add_item(kprm_pkg::KIND_CLEAR, KEY_W'($urandom_range(0, 255)));
         end else begin
            case (style)
               0: levels = KEY_W'($urandom_range(0, 255));
               1: levels = ~levels;
               2: levels = levels ^ (8'd1 << $urandom_range(0, 7));
               default: levels = ($urandom_range(0, 1) == 0) ? 8'd0
                                                             : 8'd1 << $urandom_range(0, 7);
            endcase
            add_item(kprm_pkg::KIND_FRAME, levels);
         end
      end
   endtask

   initial begin
      logic [MULT_W-1:0] mult_plan [7];
      mult_plan = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd255, 8'd1, 8'd1};
      mult_plan[4] = MULT_W'($urandom_range(2, 254));
      mult_plan[6] = MULT_W'($urandom_range(2, 254));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_multiplier(kprm_pkg::MULT_RESET);

      add_item(kprm_pkg::KIND_FRAME, 8'h00);
      add_item(kprm_pkg::KIND_FRAME, 8'hFF);
      add_item(kprm_pkg::KIND_FRAME, 8'hFF);
      add_item(kprm_pkg::KIND_FRAME, 8'h00);
      add_item(kprm_pkg::KIND_FRAME, 8'hFF);
      add_item(kprm_pkg::KIND_FRAME, 8'h55);
      add_item(kprm_pkg::KIND_FRAME, 8'hAA);
      add_item(kprm_pkg::KIND_FRAME, 8'h55);
      add_item(kprm_pkg::KIND_FRAME, 8'h01);
      add_item(kprm_pkg::KIND_FRAME, 8'h80);
      add_item(kprm_pkg::KIND_FRAME, 8'h00);
      add_item(kprm_pkg::KIND_CLEAR, 8'h00);
      add_item(kprm_pkg::KIND_FRAME, 8'hFF);
      add_item(kprm_pkg::KIND_FRAME, 8'h00);
      add_item(kprm_pkg::KIND_FRAME, 8'hFF);
      add_item(kprm_pkg::KIND_CLEAR, 8'hFF);
      add_item(kprm_pkg::KIND_CLEAR, 8'h5A);
      add_item(kprm_pkg::KIND_FRAME, 8'h00);
      add_item(kprm_pkg::KIND_FRAME, 8'hFF);
      add_item(kprm_pkg::KIND_FRAME, 8'h0F);
      add_item(kprm_pkg::KIND_FRAME, 8'hF0);
      play_items();
      drain();

      for (int p = 0; p < 7; p++) begin
         write_multiplier(mult_plan[p]);
         build_random_phase(PHASE_ITEMS);
         if (p == 2) hold_requests <= hold_requests + 1;
         play_items();
         drain();
      end

      repeat (30) @(posedge clock);
      $display("Ran %0d frame items and %0d clear items under %0d multiplier settings.",
               frame_items, clear_items, settings);
      $display("Checked %0d responses, with bursty requests and a long response hold-off.",
               checked);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
